// File: sv/ic_pkg.sv
// shared types and constants of the inversion counter
`default_nettype none

package ic_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = 19;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] pair_count;
    logic             too_many;
  } out_t;

  // one element travelling down the cell row with its partial count
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic               last;
    logic               dropped;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   greater;
  } token_t;

endpackage

`default_nettype wire

// File: sv/ic_cell.sv
// one cell of the row: holds one stored element and counts greater ones
`default_nettype none

module ic_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [ic_pkg::IDX_W-1:0] cell_idx,
  input  wire ic_pkg::token_t    tok_in,
  output ic_pkg::token_t         tok_out
);
  import ic_pkg::*;

  logic signed [31:0] elem_r;
  token_t             tok_r;
  token_t             tok_nxt;
  logic               hit;

  // only cells below the token's own slot hold earlier elements of its set
  assign hit = !tok_in.dropped && (cell_idx < tok_in.idx) && (elem_r > tok_in.value);

  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.greater = tok_in.greater + IDX_W'(1);
    end
  end

  // only the valid bit is reset, the payload just follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      tok_r <= tok_nxt;
      if (tok_in.valid && !tok_in.dropped && (tok_in.idx == cell_idx)) begin
        elem_r <= tok_in.value;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: sv/ic_total.sv
// end of the row: running total, overflow flag and result register
`default_nettype none

module ic_total (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,
  input  wire ic_pkg::token_t tok_in,
  input  wire logic           out_ready,
  output logic                out_valid,
  output ic_pkg::out_t        out_data
);
  import ic_pkg::*;

  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;
  logic             ovf_r;
  logic             out_valid_r;
  out_t             out_data_r;
  logic [CNT_W:0]   sum;

  assign sum = {1'b0, total_r} + (CNT_W+1)'(tok_in.greater);

  always_comb begin
    if (tok_in.dropped) begin
      total_nxt = total_r;
    end else if (sum > {1'b0, COUNT_MAX}) begin
      total_nxt = COUNT_MAX;
    end else begin
      total_nxt = sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may load in the same cycle the old one transfers
      if (advance && tok_in.valid && tok_in.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance && tok_in.valid) begin
        if (tok_in.last) begin
          total_r <= '0;
          ovf_r   <= 1'b0;
        end else begin
          total_r <= total_nxt;
          ovf_r   <= ovf_r | tok_in.dropped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in.valid && tok_in.last) begin
      out_data_r.pair_count <= total_nxt;
      out_data_r.too_many   <= ovf_r | tok_in.dropped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: sv/inversion_counter_top.sv
// inversion counter top level: slot counter, cell row and result stage
//
//  channel | valid     | ready     | payload
//  input   | in_valid  | in_ready  | in_data  (value, last)
//  result  | out_valid | out_ready | out_data (pair_count, too_many)
//
// one element per cycle enters unless the row freezes; each passes a row of MAX_ITEMS
// cells, each holding it in a register, and then out_valid rises in the result stage
// the row length sets the latency; throughput is one element per cycle unless frozen
// reset clears the slot counter, the token valid bits and the totals, no stored data
// a waiting result that is not taken freezes the whole row and drops in_ready
`default_nettype none

module inversion_counter_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ic_pkg::in_t  in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ic_pkg::out_t      out_data
);
  import ic_pkg::*;

  logic             advance;
  logic [IDX_W:0]   cnt_r;
  logic [IDX_W:0]   cnt_nxt;
  logic             full;
  token_t           chain [0:MAX_ITEMS];

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign full     = (cnt_r == (IDX_W+1)'(MAX_ITEMS));

  always_comb begin
    chain[0].valid   = in_valid;
    chain[0].value   = in_data.value;
    chain[0].last    = in_data.last;
    chain[0].dropped = full;
    chain[0].idx     = cnt_r[IDX_W-1:0];
    chain[0].greater = '0;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_data.last) begin
      cnt_nxt = '0;
    end else if (!full) begin
      cnt_nxt = cnt_r + (IDX_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_valid && in_ready) begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    ic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (IDX_W'(k)),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
  end

  ic_total u_total (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .tok_in    (chain[MAX_ITEMS]),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: bench/tb_inversion_counter_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the inversion counter top level
module tb_inversion_counter_top;
  import ic_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DIR_ROWS    = 18;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               typed;
    logic [CNT_W-1:0]   count;
  } dir_row_t;

  // short sets whose count is plain to see
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{32'sd0,           1'b1, 1'b1, 19'd0},
    '{32'sh8000_0000,   1'b1, 1'b1, 19'd0},
    '{32'sh7fff_ffff,   1'b0, 1'b0, 19'd0},
    '{32'sh8000_0000,   1'b1, 1'b1, 19'd1},
    '{32'sh8000_0000,   1'b0, 1'b0, 19'd0},
    '{32'sh7fff_ffff,   1'b1, 1'b1, 19'd0},
    // equal values never count
    '{32'sd5,           1'b0, 1'b0, 19'd0},
    '{32'sd5,           1'b0, 1'b0, 19'd0},
    '{32'sd5,           1'b1, 1'b1, 19'd0},
    // strictly falling across the sign boundary
    '{32'sh7fff_ffff,   1'b0, 1'b0, 19'd0},
    '{32'sd0,           1'b0, 1'b0, 19'd0},
    '{-32'sd1,          1'b0, 1'b0, 19'd0},
    '{32'sh8000_0000,   1'b1, 1'b1, 19'd6},
    '{-32'sd1,          1'b0, 1'b0, 19'd0},
    '{32'sd1,           1'b0, 1'b0, 19'd0},
    '{-32'sd1,          1'b1, 1'b1, 19'd1},
    '{32'sh5555_5555,   1'b0, 1'b0, 19'd0},
    '{32'shaaaa_aaaa,   1'b1, 1'b1, 19'd1}
  };

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // typed expectation riding along with the offered element
  logic row_typed = 1'b0;
  out_t row_want  = '0;
  logic hold_req  = 1'b0;

  int          kept_vals [MAX_ITEMS];
  int unsigned kept_n    = 0;
  int unsigned run_total = 0;
  bit          spilled   = 1'b0;
  out_t        pending_counts [$];

  int err_cnt       = 0;
  int quiet         = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit hold_seen     = 1'b0;

  inversion_counter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // adds one element to the current set, returns 1 when the set closes
  function automatic bit absorb_element(input in_t d, output out_t res);
    int unsigned greater;
    int unsigned sum;
    greater = 0;
    res     = '0;
    if (kept_n < MAX_ITEMS) begin
      for (int k = 0; k < kept_n; k++) begin
        if (kept_vals[k] > int'(d.value)) greater++;
      end
      sum       = run_total + greater;
      run_total = (sum > COUNT_MAX) ? COUNT_MAX : sum;
      kept_vals[kept_n] = int'(d.value);
      kept_n++;
    end else begin
      spilled = 1'b1;
    end
    if (!d.last) return 1'b0;
    res.pair_count = CNT_W'(run_total);
    res.too_many   = spilled;
    kept_n    = 0;
    run_total = 0;
    spilled   = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return 32'($urandom_range(8)) - 32'd4;
      1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      2: return 32'($urandom_range(1000)) - 32'd500;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6, 1);
    if (r < 95) return $urandom_range(30, 7);
    return $urandom_range(120, 31);
  endfunction

  task automatic offer(input logic signed [31:0] v, input logic lst, input logic typed,
                       input logic [CNT_W-1:0] cnt);
    in_t  d;
    out_t w;
    d.value      = v;
    d.last       = lst;
    w.pair_count = cnt;
    w.too_many   = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= d;
    row_typed <= typed;
    row_want  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) offer(pick_value(), i == len - 1, 1'b0, '0);
  endtask

  task automatic random_sets(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = pick_len();
      send_set(len);
      sent += len;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // predictor, scoreboard and watchdog
  always @(posedge clk) begin : monitor
    out_t calc;
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (absorb_element(in_data, calc))
          pending_counts.insert(pending_counts.size(), row_typed ? row_want : calc);
      end
      if (out_valid && out_ready) begin
        if (pending_counts.size() == 0) begin
          $display("%0t: result transfer expected none actual count %0d too_many %0b",
                   $time, out_data.pair_count, out_data.too_many);
          err_cnt++;
        end else begin
          want = pending_counts.pop_front();
          if (out_data.pair_count !== want.pair_count) begin
            $display("%0t: pair_count expected %0d actual %0d", $time,
                     want.pair_count, out_data.pair_count);
            err_cnt++;
          end
          if (out_data.too_many !== want.too_many) begin
            $display("%0t: too_many expected %0b actual %0b", $time,
                     want.too_many, out_data.too_many);
            err_cnt++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      offer(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].count);
    wait_drained();

    send_idle_pct = 30;
    recv_idle_pct = 84;
    random_sets(320);
    wait_drained();

    send_idle_pct = 84;
    recv_idle_pct = 30;
    random_sets(320);
    wait_drained();

    // results back up behind the hold-off until the row freezes the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    random_sets(40);
    // overfull set, its closing element is itself dropped
    send_set(MAX_ITEMS + 2);
    random_sets(120);
    wait_drained();

    repeat (MAX_ITEMS + 64) @(posedge clk);
    if (err_cnt == 0 && pending_counts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ic_pkg.sv
sv/ic_cell.sv
sv/ic_total.sv
sv/inversion_counter_top.sv
bench/tb_inversion_counter_top.sv
